>>> rtl/snah_pkg.sv
`timescale 1ns / 1ps

package snah_pkg;

    // Default geometry of the ports
    localparam int COORD_WIDTH_DEF = 48;
    localparam int COORD_FRACTION_BITS_DEF = 16;
    localparam int NOISE_WIDTH_DEF = 16;

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH = 64;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NOISE_SEED = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNIT_RANGE_MODE = 8'd1;

    // Internal fixed point: Q30 offsets
    localparam int IFB = 30;
    localparam int XW = 34;
    localparam logic [30:0] SKEW_Q32 = 31'd1572067139;
    localparam logic [29:0] UNSKEW_Q32 = 30'd907633386;
    localparam logic signed [XW-1:0] UNSKEW_Q30 = 34'sd226908346;
    localparam logic signed [XW-1:0] ONE_Q = 34'sd1073741824;
    localparam logic [39:0] HALF_Q = 40'd536870912;
    localparam int GRAD_X_BIT = 57;
    localparam int GRAD_Y_BIT = 47;
    localparam logic signed [42:0] NOISE_SCALE = 43'sd70;

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // GF(2^8) doubling
    function automatic logic [7:0] xt(input logic [7:0] b);
        xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gm9(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xt(a);
        a4 = xt(a2);
        a8 = xt(a4);
        gm9 = a8 ^ a;
    endfunction

    function automatic logic [7:0] gm11(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xt(a);
        a4 = xt(a2);
        a8 = xt(a4);
        gm11 = a8 ^ a2 ^ a;
    endfunction

    function automatic logic [7:0] gm13(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xt(a);
        a4 = xt(a2);
        a8 = xt(a4);
        gm13 = a8 ^ a4 ^ a;
    endfunction

    function automatic logic [7:0] gm14(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xt(a);
        a4 = xt(a2);
        a8 = xt(a4);
        gm14 = a8 ^ a4 ^ a2;
    endfunction

    // One inverse AES round; byte i sits at bits [8i+7:8i]
    function automatic logic [127:0] inv_round(input logic [127:0] st, input logic [127:0] key);
        logic [7:0] sb [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] res;
        res = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sb[r + 4 * c] = INV_SBOX[st[8 * (r + 4 * ((c + 4 - r) & 3)) +: 8]];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = sb[4 * c];
            a1 = sb[4 * c + 1];
            a2 = sb[4 * c + 2];
            a3 = sb[4 * c + 3];
            res[32 * c +: 8] = gm14(a0) ^ gm11(a1) ^ gm13(a2) ^ gm9(a3) ^ key[32 * c +: 8];
            res[32 * c + 8 +: 8] = gm9(a0) ^ gm14(a1) ^ gm11(a2) ^ gm13(a3)
                ^ key[32 * c + 8 +: 8];
            res[32 * c + 16 +: 8] = gm13(a0) ^ gm9(a1) ^ gm14(a2) ^ gm11(a3)
                ^ key[32 * c + 16 +: 8];
            res[32 * c + 24 +: 8] = gm11(a0) ^ gm13(a1) ^ gm9(a2) ^ gm14(a3)
                ^ key[32 * c + 24 +: 8];
        end
        inv_round = res;
    endfunction

endpackage

>>> rtl/snah_if.sv
`timescale 1ns / 1ps

interface snah_point_if #(
    parameter int COORD_WIDTH = snah_pkg::COORD_WIDTH_DEF
);
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink (input valid, input point_x, input point_y, output ready);
endinterface

interface snah_noise_if #(
    parameter int NOISE_WIDTH = snah_pkg::NOISE_WIDTH_DEF
);
    logic valid;
    logic ready;
    logic signed [NOISE_WIDTH-1:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink (input valid, input noise_value, output ready);
endinterface

interface snah_cfg_if;
    logic valid;
    logic ready;
    logic [snah_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [snah_pkg::CFG_DATA_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/simplex_noise_2d_aes_hash_unit.sv
`timescale 1ns / 1ps
// 2D simplex noise with AES corner hash, eleven register stages.
// Throughput: one point per cycle; the whole pipe holds while the output beat waits.
// Stage depth is set by the 34x34 squaring multipliers and one inverse AES round.
// Reset (rst_n low, asynchronous) empties the pipe and clears seed and mode to zero.
module simplex_noise_2d_aes_hash_unit #(
    parameter int COORD_WIDTH = snah_pkg::COORD_WIDTH_DEF,
    parameter int COORD_FRACTION_BITS = snah_pkg::COORD_FRACTION_BITS_DEF,
    parameter int NOISE_WIDTH = snah_pkg::NOISE_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    snah_point_if.sink   point,
    snah_noise_if.source noise,
    snah_cfg_if.sink     cfg
);

    localparam int XW = snah_pkg::XW;
    localparam int IFB = snah_pkg::IFB;
    localparam int NSTAGE = 11;
    localparam int OUT_SHIFT = IFB - (NOISE_WIDTH - 1);
    localparam logic signed [43:0] OUT_HI = 44'sd1 <<< (NOISE_WIDTH - 1);
    localparam logic signed [43:0] SAT_HI = OUT_HI - 44'sd1;
    localparam logic signed [43:0] SAT_LO = -OUT_HI;

    // Configuration registers
    logic [63:0] seed_reg;
    logic        mode_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            mode_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == snah_pkg::REG_NOISE_SEED)
            begin
                seed_reg <= cfg.data;
            end
            else if (cfg.index == snah_pkg::REG_UNIT_RANGE_MODE)
            begin
                mode_reg <= cfg.data[0];
            end
        end
    end

    // Pipe advance: hold everything while the output beat waits
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic              en;

    assign en = !vld_reg[NSTAGE-1] || noise.ready;
    assign point.ready = en;
    assign vld_next = {vld_reg[NSTAGE-2:0], point.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: skew partial products
    logic signed [63:0] pxs, pys;
    logic signed [63:0] kf;
    logic [63:0] lxp, lyp;
    logic signed [63:0] p1_x_reg, p1_y_reg;
    logic [63:0] p1_hx_reg, p1_hy_reg;
    logic [31:0] p1_lx_reg, p1_ly_reg;

    assign pxs = 64'($signed(point.point_x[COORD_WIDTH-1:0]));
    assign pys = 64'($signed(point.point_y[COORD_WIDTH-1:0]));
    assign kf = 64'($signed({1'b0, snah_pkg::SKEW_Q32}));
    assign lxp = 64'(pxs[31:0]) * 64'(snah_pkg::SKEW_Q32);
    assign lyp = 64'(pys[31:0]) * 64'(snah_pkg::SKEW_Q32);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_x_reg <= pxs;
            p1_y_reg <= pys;
            p1_hx_reg <= 64'(64'($signed(pxs[63:32])) * kf);
            p1_hy_reg <= 64'(64'($signed(pys[63:32])) * kf);
            p1_lx_reg <= lxp[63:32];
            p1_ly_reg <= lyp[63:32];
        end
    end

    // Stage 2: skewed point, lattice cell and in-cell fraction
    logic [63:0] skew, sx, sy;
    logic [63:0] p2_ix_reg, p2_iy_reg;
    logic [29:0] p2_fx_reg, p2_fy_reg;

    assign skew = p1_hx_reg + 64'(p1_lx_reg) + p1_hy_reg + 64'(p1_ly_reg);
    assign sx = p1_x_reg + skew;
    assign sy = p1_y_reg + skew;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_ix_reg <= 64'($signed(sx) >>> COORD_FRACTION_BITS);
            p2_iy_reg <= 64'($signed(sy) >>> COORD_FRACTION_BITS);
            p2_fx_reg <= 30'(sx[COORD_FRACTION_BITS-1:0]) << (IFB - COORD_FRACTION_BITS);
            p2_fy_reg <= 30'(sy[COORD_FRACTION_BITS-1:0]) << (IFB - COORD_FRACTION_BITS);
        end
    end

    // Stage 3: unskew term
    logic [30:0] fsum;
    logic [60:0] tq_prod;
    logic [63:0] p3_ix_reg, p3_iy_reg;
    logic [29:0] p3_fx_reg, p3_fy_reg, p3_tq_reg;

    assign fsum = 31'(p2_fx_reg) + 31'(p2_fy_reg);
    assign tq_prod = 61'(fsum) * 61'(snah_pkg::UNSKEW_Q32);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_ix_reg <= p2_ix_reg;
            p3_iy_reg <= p2_iy_reg;
            p3_fx_reg <= p2_fx_reg;
            p3_fy_reg <= p2_fy_reg;
            p3_tq_reg <= 30'(tq_prod >> 32);
        end
    end

    // Stage 4: corner offsets, corner cells and first hash round
    logic signed [XW-1:0] x0, y0;
    logic                 upper;
    logic signed [XW-1:0] cx_off [3];
    logic signed [XW-1:0] cy_off [3];
    logic [63:0]          ccx [3];
    logic [63:0]          ccy [3];
    logic signed [XW-1:0] p4_x_reg [3];
    logic signed [XW-1:0] p4_y_reg [3];
    logic [127:0]         p4_h_reg [3];

    assign x0 = $signed(XW'(p3_fx_reg)) - $signed(XW'(p3_tq_reg));
    assign y0 = $signed(XW'(p3_fy_reg)) - $signed(XW'(p3_tq_reg));
    assign upper = x0 > y0;

    always_comb
    begin
        cx_off[0] = x0;
        cy_off[0] = y0;
        cx_off[1] = x0 - (upper ? snah_pkg::ONE_Q : '0) + snah_pkg::UNSKEW_Q30;
        cy_off[1] = y0 - (upper ? '0 : snah_pkg::ONE_Q) + snah_pkg::UNSKEW_Q30;
        cx_off[2] = x0 - snah_pkg::ONE_Q + (snah_pkg::UNSKEW_Q30 <<< 1);
        cy_off[2] = y0 - snah_pkg::ONE_Q + (snah_pkg::UNSKEW_Q30 <<< 1);
        ccx[0] = p3_ix_reg;
        ccy[0] = p3_iy_reg;
        ccx[1] = p3_ix_reg + 64'(upper);
        ccy[1] = p3_iy_reg + 64'(!upper);
        ccx[2] = p3_ix_reg + 64'd1;
        ccy[2] = p3_iy_reg + 64'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p4_x_reg[k] <= cx_off[k];
                p4_y_reg[k] <= cy_off[k];
                p4_h_reg[k] <= snah_pkg::inv_round({seed_reg, seed_reg}, {ccx[k], ccy[k]});
            end
        end
    end

    // Stage 5: second hash round, squares of the offsets
    logic signed [67:0]   sqx [3];
    logic signed [67:0]   sqy [3];
    logic signed [XW-1:0] p5_x_reg [3];
    logic signed [XW-1:0] p5_y_reg [3];
    logic [127:0]         p5_h_reg [3];
    logic [37:0]          p5_xx_reg [3];
    logic [37:0]          p5_yy_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sqx[k] = 68'(p4_x_reg[k]) * 68'(p4_x_reg[k]);
            sqy[k] = 68'(p4_y_reg[k]) * 68'(p4_y_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p5_x_reg[k] <= p4_x_reg[k];
                p5_y_reg[k] <= p4_y_reg[k];
                p5_h_reg[k] <= snah_pkg::inv_round(p4_h_reg[k], p4_h_reg[k]);
                p5_xx_reg[k] <= 38'(sqx[k] >>> IFB);
                p5_yy_reg[k] <= 38'(sqy[k] >>> IFB);
            end
        end
    end

    // Stage 6: third hash round, falloff clamped at zero
    logic signed [39:0]   fall [3];
    logic signed [XW-1:0] p6_x_reg [3];
    logic signed [XW-1:0] p6_y_reg [3];
    logic [127:0]         p6_h_reg [3];
    logic [29:0]          p6_t_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            fall[k] = $signed(snah_pkg::HALF_Q - 40'(p5_xx_reg[k]) - 40'(p5_yy_reg[k]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p6_x_reg[k] <= p5_x_reg[k];
                p6_y_reg[k] <= p5_y_reg[k];
                p6_h_reg[k] <= snah_pkg::inv_round(p5_h_reg[k], p5_h_reg[k]);
                p6_t_reg[k] <= fall[k][39] ? '0 : fall[k][29:0];
            end
        end
    end

    // Stage 7: last hash round, falloff squared
    logic [59:0]          t2p [3];
    logic signed [XW-1:0] p7_x_reg [3];
    logic signed [XW-1:0] p7_y_reg [3];
    logic [127:0]         p7_h_reg [3];
    logic [28:0]          p7_t2_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t2p[k] = 60'(p6_t_reg[k]) * 60'(p6_t_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p7_x_reg[k] <= p6_x_reg[k];
                p7_y_reg[k] <= p6_y_reg[k];
                p7_h_reg[k] <= snah_pkg::inv_round(p6_h_reg[k], p6_h_reg[k]);
                p7_t2_reg[k] <= 29'(t2p[k] >> IFB);
            end
        end
    end

    // Stage 8: fourth power of the falloff, take the gradient signs
    logic [57:0]          t4p [3];
    logic signed [XW-1:0] p8_x_reg [3];
    logic signed [XW-1:0] p8_y_reg [3];
    logic                 p8_gx_reg [3];
    logic                 p8_gy_reg [3];
    logic [28:0]          p8_t4_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t4p[k] = 58'(p7_t2_reg[k]) * 58'(p7_t2_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p8_x_reg[k] <= p7_x_reg[k];
                p8_y_reg[k] <= p7_y_reg[k];
                p8_gx_reg[k] <= p7_h_reg[k][snah_pkg::GRAD_X_BIT];
                p8_gy_reg[k] <= p7_h_reg[k][snah_pkg::GRAD_Y_BIT];
                p8_t4_reg[k] <= 29'(t4p[k] >> IFB);
            end
        end
    end

    // Stage 9: gradient dot product times falloff
    logic signed [34:0] dotv [3];
    logic signed [63:0] termp [3];
    logic signed [33:0] p9_term_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dotv[k] = (p8_gx_reg[k] ? 35'(p8_x_reg[k]) : -35'(p8_x_reg[k]))
                + (p8_gy_reg[k] ? 35'(p8_y_reg[k]) : -35'(p8_y_reg[k]));
            termp[k] = 64'($signed({1'b0, p8_t4_reg[k]})) * 64'(dotv[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p9_term_reg[k] <= 34'(termp[k] >>> IFB);
            end
        end
    end

    // Stage 10: sum of corners, scaled
    logic signed [35:0] csum;
    logic signed [42:0] p10_v_reg;

    assign csum = 36'(p9_term_reg[0]) + 36'(p9_term_reg[1]) + 36'(p9_term_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p10_v_reg <= 43'(csum) * snah_pkg::NOISE_SCALE;
        end
    end

    // Stage 11: range mode, drop fraction bits, saturate
    logic signed [43:0] vm, vr, vs;
    logic [NOISE_WIDTH-1:0] out_reg;

    assign vm = mode_reg ? ((44'(p10_v_reg) + 44'(snah_pkg::ONE_Q)) >>> 1) : 44'(p10_v_reg);
    assign vr = vm >>> OUT_SHIFT;
    assign vs = (vr > SAT_HI) ? SAT_HI : ((vr < SAT_LO) ? SAT_LO : vr);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= vs[NOISE_WIDTH-1:0];
        end
    end

    assign noise.valid = vld_reg[NSTAGE-1];
    assign noise.noise_value = $signed(out_reg);

endmodule
